// ----- rtl/matrix_multiply_core_macros.svh -----
// ----------------------------------------------------------------------------
// matrix_multiply_core_macros.svh
// Assertion shorthands shared by the matrix multiply RTL. They expect clk and
// rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef MATRIX_MULTIPLY_CORE_MACROS_SVH
`define MATRIX_MULTIPLY_CORE_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define MM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mm assertion failed");

// Next-cycle implication, checked out of reset.
`define MM_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mm assertion failed");

`endif

// ----- rtl/mm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mm_pkg
// Shared widths, codes and the tag that rides along the MAC pipeline.
// ----------------------------------------------------------------------------
package mm_pkg;

  localparam int MAX_DIM_DEF = 8;

  localparam int IDX_W  = 3;   // row / column index fields
  localparam int DIM_W  = 4;   // dimension registers
  localparam int VAL_W  = 16;  // Q8.8 element
  localparam int PROD_W = 32;  // Q16.16 element product / result
  localparam int ACT_W  = 2;
  localparam int CFG_IDX_W = 2;

  localparam logic [ACT_W-1:0] ACT_WR_A = 2'd0;
  localparam logic [ACT_W-1:0] ACT_WR_B = 2'd1;
  localparam logic [ACT_W-1:0] ACT_MUL  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_A    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INNER_DIM = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS_B    = 2'd2;

  localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;

  typedef struct packed {
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic             first_k;    // first term of a dot product
    logic             last_k;     // final term of a dot product
    logic             last_elem;  // final product element of the run
  } mm_tag_t;

endpackage

// ----- rtl/mm_store.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mm_store
// One element store: single write port, single read port, registered read.
// ----------------------------------------------------------------------------
module mm_store #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [AW-1:0]            wr_addr,
  input  logic [mm_pkg::VAL_W-1:0] wr_data,
  input  logic                     rd_en,
  input  logic [AW-1:0]            rd_addr,
  output logic [mm_pkg::VAL_W-1:0] rd_data
);
  import mm_pkg::*;

  logic [VAL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- rtl/mm_seq.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mm_seq
// Run sequencer: walks i, j, k and issues one A and one B read per cycle while pipe_en is high.
// ----------------------------------------------------------------------------
`include "matrix_multiply_core_macros.svh"
module mm_seq #(
  parameter int MAX_DIM = mm_pkg::MAX_DIM_DEF,
  parameter int IW      = 3,
  parameter int AW      = 6
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [mm_pkg::DIM_W-1:0] rows_a,
  input  logic [mm_pkg::DIM_W-1:0] inner_dim,
  input  logic [mm_pkg::DIM_W-1:0] cols_b,
  input  logic                     pipe_en,
  output logic                     busy,
  output logic                     rd_en,
  output logic [AW-1:0]            a_addr,
  output logic [AW-1:0]            b_addr,
  output logic                     issue_valid,
  output mm_pkg::mm_tag_t          issue_tag
);
  import mm_pkg::*;

  localparam logic [IW-1:0]    LIM_MAX = IW'(MAX_DIM - 1);
  localparam logic [DIM_W-1:0] DIM_MAX = DIM_W'(MAX_DIM);

  logic          busy_r, busy_nxt;
  logic [IW-1:0] i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;
  logic [IW-1:0] nr_lim_r, nk_lim_r, nc_lim_r;
  logic          k_end, j_end, i_end, step;

  // Register value 0 acts as 1, values above MAX_DIM act as MAX_DIM.
  function automatic logic [IW-1:0] dim_lim(input logic [DIM_W-1:0] d);
    logic [DIM_W-1:0] dm1;
    dm1 = d - DIM_W'(1);
    if (d == '0) begin
      return '0;
    end else if (d > DIM_MAX) begin
      return LIM_MAX;
    end else begin
      return dm1[IW-1:0];
    end
  endfunction

  assign k_end = (k_r == nk_lim_r);
  assign j_end = (j_r == nc_lim_r);
  assign i_end = (i_r == nr_lim_r);
  assign step  = busy_r && pipe_en;

  always_comb begin
    busy_nxt = busy_r;
    i_nxt    = i_r;
    j_nxt    = j_r;
    k_nxt    = k_r;
    if (start && !busy_r) begin
      busy_nxt = 1'b1;
      i_nxt    = '0;
      j_nxt    = '0;
      k_nxt    = '0;
    end else if (step) begin
      k_nxt = k_end ? '0 : k_r + IW'(1);
      if (k_end) begin
        j_nxt = j_end ? '0 : j_r + IW'(1);
        if (j_end) begin
          i_nxt = i_end ? '0 : i_r + IW'(1);
          if (i_end) begin
            busy_nxt = 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      i_r    <= '0;
      j_r    <= '0;
      k_r    <= '0;
    end else begin
      busy_r <= busy_nxt;
      i_r    <= i_nxt;
      j_r    <= j_nxt;
      k_r    <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy_r) begin
      nr_lim_r <= dim_lim(rows_a);
      nk_lim_r <= dim_lim(inner_dim);
      nc_lim_r <= dim_lim(cols_b);
    end
  end

  assign busy        = busy_r;
  assign rd_en       = step;
  assign issue_valid = busy_r;
  assign a_addr      = AW'(i_r) * AW'(MAX_DIM) + AW'(k_r);
  assign b_addr      = AW'(k_r) * AW'(MAX_DIM) + AW'(j_r);

  always_comb begin
    issue_tag.row       = IDX_W'(i_r);
    issue_tag.col       = IDX_W'(j_r);
    issue_tag.first_k   = (k_r == '0);
    issue_tag.last_k    = k_end;
    issue_tag.last_elem = i_end && j_end;
  end

  `MM_ASSERT_IMP(a_cnt_bounds, busy_r, (k_r <= nk_lim_r) && (j_r <= nc_lim_r) && (i_r <= nr_lim_r))
  `MM_ASSERT_IMP(a_run_end, $fell(busy_r) && $past(rst_n), $past(i_end && j_end && k_end && pipe_en))

endmodule

// ----- rtl/mm_mac.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mm_mac
// Multiply, accumulate over k, saturate to 32 bits, hold the result for
// transfer. The whole pipe freezes while a result waits under stall.
// ----------------------------------------------------------------------------
`include "matrix_multiply_core_macros.svh"
module mm_mac #(
  parameter int MAX_DIM = mm_pkg::MAX_DIM_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      issue_valid,
  input  mm_pkg::mm_tag_t           issue_tag,
  input  logic [mm_pkg::VAL_W-1:0]  a_data,
  input  logic [mm_pkg::VAL_W-1:0]  b_data,
  output logic                      pipe_en,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [mm_pkg::IDX_W-1:0]  out_row,
  output logic [mm_pkg::IDX_W-1:0]  out_col,
  output logic [mm_pkg::PROD_W-1:0] out_product_value,
  output logic                      out_last
);
  import mm_pkg::*;

  localparam int ACC_W = PROD_W + $clog2(MAX_DIM) + 1;

  logic                     s1_valid_r, s2_valid_r, out_valid_r;
  mm_tag_t                  s1_tag_r, s2_tag_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r, acc_nxt, prod_ext;
  logic [PROD_W-1:0]        sat_val;
  logic                     sat_hi, sat_lo, load_out;
  logic [IDX_W-1:0]         row_r, col_r;
  logic [PROD_W-1:0]        res_r;
  logic                     last_r;

  assign pipe_en  = !(out_valid_r && out_stall);
  assign load_out = pipe_en && s2_valid_r && s2_tag_r.last_k;

  assign prod_ext = {{(ACC_W - PROD_W){prod_r[PROD_W-1]}}, prod_r};
  assign acc_nxt  = (s2_tag_r.first_k ? '0 : acc_r) + prod_ext;

  // Out of range when bit 31 and the bits above it are not all copies of the sign.
  assign sat_hi  = !acc_nxt[ACC_W-1] && (|acc_nxt[ACC_W-2:PROD_W-1]);
  assign sat_lo  = acc_nxt[ACC_W-1] && !(&acc_nxt[ACC_W-2:PROD_W-1]);
  assign sat_val = sat_hi ? {1'b0, {(PROD_W-1){1'b1}}} :
                   sat_lo ? {1'b1, {(PROD_W-1){1'b0}}} : acc_nxt[PROD_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (pipe_en) begin
        s1_valid_r <= issue_valid;
        s2_valid_r <= s1_valid_r;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      s1_tag_r <= issue_tag;
      s2_tag_r <= s1_tag_r;
      prod_r   <= $signed(a_data) * $signed(b_data);
      if (s2_valid_r) begin
        acc_r <= acc_nxt;
      end
    end
    if (load_out) begin
      row_r  <= s2_tag_r.row;
      col_r  <= s2_tag_r.col;
      res_r  <= sat_val;
      last_r <= s2_tag_r.last_elem;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_row           = row_r;
  assign out_col           = col_r;
  assign out_product_value = res_r;
  assign out_last          = last_r;

  `MM_ASSERT_NXT(a_pipe_hold, !pipe_en, $stable(s2_valid_r) && $stable(s1_valid_r))
  `MM_ASSERT_NXT(a_res_first, load_out && s2_tag_r.first_k, res_r == $past(sat_val))

endmodule

// ----- rtl/matrix_multiply_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_multiply_core
// Q8.8 matrix multiply with two element stores and a single MAC pipeline.
// ----------------------------------------------------------------------------
// Element loads (action 0 for A, 1 for B) write one element each. A multiply
// item holds in_stall high for the run, while the sequencer reads one A and
// one B element per cycle unless the MAC pipe is frozen, one read port per
// store; product elements leave in row-major order through the store read,
// product and result registers, with out_last on the final one. A result
// under out_stall freezes the whole MAC pipe and sequencer, so runs lengthen.
// The next item is taken as soon as the last read has been issued. The user
// must change dimension registers only when idle; not enforced by the block.
`include "matrix_multiply_core_macros.svh"
module matrix_multiply_core #(
  parameter int MAX_DIM = mm_pkg::MAX_DIM_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [mm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mm_pkg::DIM_W-1:0]     cfg_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [mm_pkg::ACT_W-1:0]     in_action,
  input  logic [mm_pkg::IDX_W-1:0]     in_row_index,
  input  logic [mm_pkg::IDX_W-1:0]     in_col_index,
  input  logic [mm_pkg::VAL_W-1:0]     in_value,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [mm_pkg::IDX_W-1:0]     out_row,
  output logic [mm_pkg::IDX_W-1:0]     out_col,
  output logic [mm_pkg::PROD_W-1:0]    out_product_value,
  output logic                         out_last
);
  import mm_pkg::*;

  localparam int IW    = $clog2(MAX_DIM);
  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = $clog2(DEPTH);

  logic [DIM_W-1:0] rows_a_r, inner_dim_r, cols_b_r;
  logic             in_xfer, in_range, wr_a, wr_b, start;
  logic [AW-1:0]    wr_addr, a_addr, b_addr;
  logic             busy, rd_en, pipe_en, issue_valid;
  mm_tag_t          issue_tag;
  logic [VAL_W-1:0] a_data, b_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_a_r    <= DIM_RESET;
      inner_dim_r <= DIM_RESET;
      cols_b_r    <= DIM_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ROWS_A:    rows_a_r    <= cfg_data;
        CFG_INNER_DIM: inner_dim_r <= cfg_data;
        CFG_COLS_B:    cols_b_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Stores are only read during a run and only written outside one.
  assign in_stall = busy;
  assign in_xfer  = in_valid && !in_stall;
  assign in_range = (32'(in_row_index) < MAX_DIM) && (32'(in_col_index) < MAX_DIM);
  assign wr_a     = in_xfer && in_range && (in_action == ACT_WR_A);
  assign wr_b     = in_xfer && in_range && (in_action == ACT_WR_B);
  assign start    = in_xfer && (in_action == ACT_MUL);
  assign wr_addr  = AW'(in_row_index) * AW'(MAX_DIM) + AW'(in_col_index);

  mm_store #(.DEPTH(DEPTH), .AW(AW)) u_store_a (
    .clk     (clk),
    .wr_en   (wr_a),
    .wr_addr (wr_addr),
    .wr_data (in_value),
    .rd_en   (rd_en),
    .rd_addr (a_addr),
    .rd_data (a_data)
  );

  mm_store #(.DEPTH(DEPTH), .AW(AW)) u_store_b (
    .clk     (clk),
    .wr_en   (wr_b),
    .wr_addr (wr_addr),
    .wr_data (in_value),
    .rd_en   (rd_en),
    .rd_addr (b_addr),
    .rd_data (b_data)
  );

  mm_seq #(.MAX_DIM(MAX_DIM), .IW(IW), .AW(AW)) u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .rows_a      (rows_a_r),
    .inner_dim   (inner_dim_r),
    .cols_b      (cols_b_r),
    .pipe_en     (pipe_en),
    .busy        (busy),
    .rd_en       (rd_en),
    .a_addr      (a_addr),
    .b_addr      (b_addr),
    .issue_valid (issue_valid),
    .issue_tag   (issue_tag)
  );

  mm_mac #(.MAX_DIM(MAX_DIM)) u_mac (
    .clk               (clk),
    .rst_n             (rst_n),
    .issue_valid       (issue_valid),
    .issue_tag         (issue_tag),
    .a_data            (a_data),
    .b_data            (b_data),
    .pipe_en           (pipe_en),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_row           (out_row),
    .out_col           (out_col),
    .out_product_value (out_product_value),
    .out_last          (out_last)
  );

  `MM_ASSERT_NXT(a_mul_starts, start, busy)
  `MM_ASSERT_IMP(a_no_wr_in_run, busy, !wr_a && !wr_b)

endmodule
